// ===== rtl/lr_pkg.sv =====
package lr_pkg;

  localparam int TILE_SIZE   = 64;
  localparam int COORD_W     = 6;
  localparam int COLOR_W     = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int ERR_W       = COORD_W + 4;

  typedef logic [COORD_W-1:0] coord_t;

  // One line command as it arrives on the input port
  typedef struct packed {
    coord_t             x_start;
    coord_t             x_end;
    coord_t             y_start;
    coord_t             y_end;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } line_cmd_t;

  // One emitted pixel
  typedef struct packed {
    coord_t             pixel_x;
    coord_t             pixel_y;
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;
    logic               last_pixel;
  } pixel_t;

  // Classified line: major axis picked, endpoints ordered upward along it
  typedef struct packed {
    logic                y_major;
    coord_t              mj0;
    coord_t              mn0;
    coord_t              dmaj;
    logic signed [COORD_W:0] dmin;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
  } line_job_t;

  // Queue status seen by the back end and by the core's busy output
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== rtl/lr_front.sv =====
module lr_front
  import lr_pkg::*;
#(
  parameter int TileSize = TILE_SIZE
) (
  input  line_cmd_t cmd_i,
  output line_job_t job_o
);

  localparam coord_t MaxCoord = COORD_W'(TileSize - 1);

  coord_t xs, xe, ys, ye;
  logic signed [COORD_W:0] dx, dy;
  coord_t adx, ady;
  logic   y_major;
  coord_t a0, a1, b0, b1;
  logic   swap;

  // Saturate coordinates to the tile
  always_comb begin
    xs = (cmd_i.x_start > MaxCoord) ? MaxCoord : cmd_i.x_start;
    xe = (cmd_i.x_end   > MaxCoord) ? MaxCoord : cmd_i.x_end;
    ys = (cmd_i.y_start > MaxCoord) ? MaxCoord : cmd_i.y_start;
    ye = (cmd_i.y_end   > MaxCoord) ? MaxCoord : cmd_i.y_end;
  end

  // Deltas and major axis; a tie picks x
  always_comb begin
    dx  = $signed({1'b0, xe}) - $signed({1'b0, xs});
    dy  = $signed({1'b0, ye}) - $signed({1'b0, ys});
    adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    y_major = ady > adx;
  end

  // Order endpoints so that stepping runs upward on the major axis
  always_comb begin
    a0   = y_major ? ys : xs;
    a1   = y_major ? ye : xe;
    b0   = y_major ? xs : ys;
    b1   = y_major ? xe : ye;
    swap = a0 > a1;

    job_o.y_major = y_major;
    job_o.mj0     = swap ? a1 : a0;
    job_o.mn0     = swap ? b1 : b0;
    job_o.dmaj    = swap ? (a0 - a1) : (a1 - a0);
    job_o.dmin    = swap ? ($signed({1'b0, b0}) - $signed({1'b0, b1}))
                         : ($signed({1'b0, b1}) - $signed({1'b0, b0}));
    job_o.red     = cmd_i.red;
    job_o.green   = cmd_i.green;
    job_o.blue    = cmd_i.blue;
  end

endmodule

// ===== rtl/lr_queue.sv =====
module lr_queue
  import lr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  line_job_t   push_data_i,
  input  logic        pop_i,
  output line_job_t   head_o,
  output queue_stat_t stat_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  line_job_t       mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue fill count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("transfer into full queue");

endmodule

// ===== rtl/lr_back.sv =====
module lr_back
  import lr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  line_job_t   head_i,
  input  queue_stat_t stat_i,
  output logic        pop_o,
  output logic        pixel_valid_o,
  output pixel_t      pixel_o
);

  logic               active_q, active_d;
  logic               ymaj_q, ymaj_d;
  coord_t             maj_q, maj_d;
  coord_t             min_q, min_d;
  coord_t             remain_q, remain_d;
  logic [COORD_W:0]   two_dmaj_q, two_dmaj_d;
  logic signed [COORD_W+1:0] two_dmin_q, two_dmin_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic [COLOR_W-1:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic               last_step;
  logic signed [ERR_W-1:0]   err_sum, two_dmaj_s;
  logic               out_valid_q, out_valid_d;
  pixel_t             out_q, out_d;

  assign last_step  = active_q && (remain_q == '0);
  assign pop_o      = !stat_i.empty && (!active_q || last_step);
  assign two_dmaj_s = $signed({{(ERR_W-COORD_W-1){1'b0}}, two_dmaj_q});
  assign err_sum    = err_q + {{(ERR_W-COORD_W-2){two_dmin_q[COORD_W+1]}}, two_dmin_q};

  // Stepper: one pixel per cycle, exact error term for the minor axis
  always_comb begin
    active_d   = active_q;
    ymaj_d     = ymaj_q;
    maj_d      = maj_q;
    min_d      = min_q;
    remain_d   = remain_q;
    two_dmaj_d = two_dmaj_q;
    two_dmin_d = two_dmin_q;
    err_d      = err_q;
    red_d      = red_q;
    green_d    = green_q;
    blue_d     = blue_q;
    if (pop_o) begin
      active_d   = 1'b1;
      ymaj_d     = head_i.y_major;
      maj_d      = head_i.mj0;
      min_d      = head_i.mn0;
      remain_d   = head_i.dmaj;
      two_dmaj_d = {head_i.dmaj, 1'b0};
      two_dmin_d = {head_i.dmin, 1'b0};
      err_d      = $signed({{(ERR_W-COORD_W){1'b0}}, head_i.dmaj});
      red_d      = head_i.red;
      green_d    = head_i.green;
      blue_d     = head_i.blue;
    end else if (last_step) begin
      active_d = 1'b0;
    end else if (active_q) begin
      maj_d    = maj_q + 1'b1;
      remain_d = remain_q - 1'b1;
      if (err_sum >= two_dmaj_s) begin
        min_d = min_q + 1'b1;
        err_d = err_sum - two_dmaj_s;
      end else if (err_sum < 0) begin
        min_d = min_q - 1'b1;
        err_d = err_sum + two_dmaj_s;
      end else begin
        err_d = err_sum;
      end
    end
  end

  // Output register contents
  always_comb begin
    out_valid_d         = active_q;
    out_d.pixel_x       = ymaj_q ? min_q : maj_q;
    out_d.pixel_y       = ymaj_q ? maj_q : min_q;
    out_d.pixel_red     = red_q;
    out_d.pixel_green   = green_q;
    out_d.pixel_blue    = blue_q;
    out_d.last_pixel    = (remain_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ymaj_q     <= ymaj_d;
    maj_q      <= maj_d;
    min_q      <= min_d;
    remain_q   <= remain_d;
    two_dmaj_q <= two_dmaj_d;
    two_dmin_q <= two_dmin_d;
    err_q      <= err_d;
    red_q      <= red_d;
    green_q    <= green_d;
    blue_q     <= blue_d;
    out_q      <= out_d;
  end

  assign pixel_valid_o = out_valid_q;
  assign pixel_o       = out_q;

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (err_q >= 0) && ((err_q < two_dmaj_s) || (err_q == 0)))
    else $error("error term out of range");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_step && !pop_o) |=> !active_q && pixel_valid_o && pixel_o.last_pixel)
    else $error("line did not end after last pixel");

endmodule

// ===== rtl/line_rasterizer_core.sv =====
// Channel   Ports                       Transfer
// command   start, busy, cmd_i          edge with start high and busy low
// pixel     pixel_valid_o, pixel_o      every edge ending a cycle with pixel_valid_o high
//
// A line of n pixels (n = major-axis span + 1) goes through the stepper one
// pixel per cycle; lines follow each other with no gap while commands wait.
// Each command passes the queue, the stepper and the output register before its
// first pixel appears. busy is high while the two-entry command queue is full.
// Reset clears the queue and the stepper; payload registers are not reset.
// The receiver cannot stall: every pixel is shown for exactly one cycle.
module line_rasterizer_core
  import lr_pkg::*;
#(
  parameter int TileSize = TILE_SIZE
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  line_cmd_t cmd_i,
  output logic      pixel_valid_o,
  output pixel_t    pixel_o
);

  line_job_t   job, head;
  queue_stat_t stat;
  logic        pop;

  assign busy = stat.full;

  lr_front #(
    .TileSize(TileSize)
  ) u_front (
    .cmd_i(cmd_i),
    .job_o(job)
  );

  lr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (start && !busy),
    .push_data_i(job),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (stat)
  );

  lr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .stat_i       (stat),
    .pop_o        (pop),
    .pixel_valid_o(pixel_valid_o),
    .pixel_o      (pixel_o)
  );

endmodule
